// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: rtl/core/lruk_pkg.sv
// Package: payload types and codes for the LRU-K replacer
package lruk_pkg;
    localparam int MAX_FRAMES = 64;

    localparam logic [1:0] MODE_RECORD = 2'd0;
    localparam logic [1:0] MODE_SETEV  = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_EVICT  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_PINNED  = 2'd3;

    localparam logic REG_DEPTH = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] frame_num;
        logic       evictable_flag;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic       evicted_valid;
        logic [5:0] evicted_frame;
        logic [6:0] evictable_count;
        logic [6:0] tracked_count;
    } out_word_t;
endpackage

// File: rtl/core/lruk_meta_ram.sv
// Per-frame metadata memory: count, write slot and first stamp, one read port
module lruk_meta_ram
    import lruk_pkg::*;
#(
    parameter int AW = 6,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/core/lruk_hist_ram.sv
// Access history memory: one stamp per frame and slot, one read port
module lruk_hist_ram
    import lruk_pkg::*;
#(
    parameter int AW = 9,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/core/lru_k_replacement_policy.sv
// LRU-K replacer: record, set-evictable and remove words pass S_RD, S_RD2, S_EXEC and S_OUT
// from accept to result. An evict word scans every frame slot through the metadata and history
// memories, one frame per cycle as the scan pipeline issues them, then passes S_DONE and S_OUT.
// One word is handled at a time; the next is accepted when the result register is free.
// Reset (rst_n low, asynchronous) clears tracking and evictable bits, counters, the stamp
// counter and the registers (k = 2, frame limit = 64); memory contents stay undefined.
module lru_k_replacement_policy
    import lruk_pkg::*;
#(
    parameter int MAX_K       = 8,
    parameter int STAMP_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [6:0] cfg_data,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);
    localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int SW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CW = $clog2(MAX_K + 1);
    localparam int NW = $clog2(MAX_FRAMES + 1);
    localparam int MW = CW + SW + STAMP_WIDTH;
    localparam int HW = FW + SW;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_RD2   = 7'b0000100,
        S_EXEC  = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_DONE  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [3:0] depth_reg;
    logic [6:0] limit_reg;
    logic [MAX_FRAMES-1:0] tracked_reg, evict_reg;
    logic [STAMP_WIDTH-1:0] time_reg;
    logic [NW-1:0] live_reg, evcnt_reg;
    in_word_t  cmd_reg;
    out_word_t res_reg;
    logic      res_valid_reg;

    // effective k
    logic [CW-1:0] k_eff;
    always_comb
    begin
        if (depth_reg == 4'd0)
            k_eff = CW'(1);
        else if (32'(depth_reg) > MAX_K)
            k_eff = CW'(MAX_K);
        else
            k_eff = CW'(depth_reg);
    end

    // memories
    logic          meta_we;
    logic [FW-1:0] meta_waddr, meta_raddr;
    logic [MW-1:0] meta_wdata, meta_rdata;
    logic          hist_we;
    logic [HW-1:0] hist_waddr, hist_raddr;
    logic [STAMP_WIDTH-1:0] hist_rdata;

    lruk_meta_ram #(.AW(FW), .DW(MW)) u_meta (
        .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
        .raddr(meta_raddr), .rdata(meta_rdata)
    );
    lruk_hist_ram #(.AW(HW), .DW(STAMP_WIDTH)) u_hist (
        .clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(time_reg),
        .raddr(hist_raddr), .rdata(hist_rdata)
    );

    logic [CW-1:0] m_cnt;
    logic [SW-1:0] m_slot;
    logic [STAMP_WIDTH-1:0] m_first;
    assign m_cnt   = meta_rdata[MW-1 -: CW];
    assign m_slot  = meta_rdata[STAMP_WIDTH +: SW];
    assign m_first = meta_rdata[STAMP_WIDTH-1:0];

    // frame index check: ids at or above MAX_FRAMES are untracked
    logic          fid_ok;
    logic [FW-1:0] fidx;
    assign fid_ok = 32'(cmd_reg.frame_num) < MAX_FRAMES;
    assign fidx   = fid_ok ? FW'(cmd_reg.frame_num) : '0;
    logic known;
    assign known = fid_ok && tracked_reg[fidx];

    // scan pipeline: stage 0 issues meta read, stage 1 issues history read,
    // stage 2 compares
    logic [FW:0]   scan_cnt_reg;
    logic          s1_v_reg, s2_v_reg;
    logic [FW-1:0] s1_idx_reg, s2_idx_reg;
    logic          s2_young_reg;
    logic [STAMP_WIDTH-1:0] s2_first_reg;
    logic          have_y_reg, have_o_reg;
    logic [FW-1:0] y_idx_reg, o_idx_reg;
    logic [STAMP_WIDTH-1:0] y_t_reg, o_t_reg;

    logic [SW-1:0] kth_slot;
    logic [SW:0]   slot_sum;
    always_comb
    begin
        // (slot + MAX_K - k) mod MAX_K, operands below 2*MAX_K
        slot_sum = (SW+1)'(m_slot) + (SW+1)'(MAX_K) - (SW+1)'(k_eff);
        if (32'(slot_sum) >= MAX_K)
            kth_slot = SW'(32'(slot_sum) - MAX_K);
        else
            kth_slot = SW'(slot_sum);
    end

    logic scanning;
    assign scanning = (state_reg == S_SCAN);
    logic scan_issue;
    assign scan_issue = scanning && (32'(scan_cnt_reg) < MAX_FRAMES);

    // memory addressing
    always_comb
    begin
        meta_raddr = fidx;
        hist_raddr = {fidx, m_slot};
        if (scanning)
        begin
            meta_raddr = scan_cnt_reg[FW-1:0];
            hist_raddr = {s1_idx_reg, kth_slot};
        end
    end

    // record access write-back
    logic [CW-1:0] new_cnt;
    logic [SW-1:0] cur_slot, new_slot;
    logic [STAMP_WIDTH-1:0] cur_first;
    always_comb
    begin
        cur_slot  = known ? m_slot : '0;
        cur_first = known ? m_first : time_reg;
        new_cnt   = known ? m_cnt : '0;
        if (32'(new_cnt) < MAX_K)
            new_cnt = new_cnt + CW'(1);
        new_slot  = (32'(cur_slot) == MAX_K - 1) ? '0 : cur_slot + SW'(1);
    end

    logic do_record;
    assign do_record = (state_reg == S_EXEC) && (cmd_reg.mode == MODE_RECORD) && fid_ok
                       && (known || 32'(live_reg) < 32'(limit_reg));
    assign meta_we    = do_record;
    assign meta_waddr = fidx;
    assign meta_wdata = {new_cnt, new_slot, cur_first};
    assign hist_we    = do_record;
    assign hist_waddr = {fidx, cur_slot};

    // victim choice
    logic          victim_v;
    logic [FW-1:0] victim;
    assign victim_v = have_y_reg || have_o_reg;
    assign victim   = have_y_reg ? y_idx_reg : o_idx_reg;

    assign in_ready  = (state_reg == S_IDLE) && !res_valid_reg;
    assign out_valid = res_valid_reg;
    assign out_word  = res_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid && in_ready) state_next = S_RD;
            S_RD:   state_next = (cmd_reg.mode == MODE_EVICT) ? S_SCAN : S_RD2;
            S_RD2:  state_next = S_EXEC;
            S_EXEC: state_next = S_OUT;
            S_SCAN: if (32'(scan_cnt_reg) >= MAX_FRAMES && !s1_v_reg && !s2_v_reg)
                        state_next = S_DONE;
            S_DONE: state_next = S_OUT;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= 4'd2;
            limit_reg     <= 7'd64;
            tracked_reg   <= '0;
            evict_reg     <= '0;
            time_reg      <= '0;
            live_reg      <= '0;
            evcnt_reg     <= '0;
            res_valid_reg <= 1'b0;
            scan_cnt_reg  <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            have_y_reg    <= 1'b0;
            have_o_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEPTH: depth_reg <= cfg_data[3:0];
                    REG_LIMIT: limit_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
                res_valid_reg <= 1'b0;

            if (state_reg == S_RD)
            begin
                // reset scan bookkeeping
                scan_cnt_reg <= '0;
                have_y_reg   <= 1'b0;
                have_o_reg   <= 1'b0;
                s1_v_reg     <= 1'b0;
                s2_v_reg     <= 1'b0;
            end

            if (state_reg == S_EXEC)
            begin
                res_reg.status        <= ST_OK;
                res_reg.evicted_valid <= 1'b0;
                res_reg.evicted_frame <= '0;
                case (cmd_reg.mode)
                    MODE_RECORD:
                    begin
                        if (!fid_ok)
                            res_reg.status <= ST_UNKNOWN;
                        else if (!known && 32'(live_reg) >= 32'(limit_reg))
                            res_reg.status <= ST_FULL;
                        else
                        begin
                            if (!known)
                            begin
                                tracked_reg[fidx] <= 1'b1;
                                evict_reg[fidx]   <= 1'b0;
                                live_reg          <= live_reg + NW'(1);
                            end
                            time_reg <= time_reg + STAMP_WIDTH'(1);
                        end
                    end
                    MODE_SETEV:
                    begin
                        if (!known)
                            res_reg.status <= ST_UNKNOWN;
                        else if (cmd_reg.evictable_flag != evict_reg[fidx])
                        begin
                            evict_reg[fidx] <= cmd_reg.evictable_flag;
                            if (cmd_reg.evictable_flag)
                                evcnt_reg <= evcnt_reg + NW'(1);
                            else
                                evcnt_reg <= evcnt_reg - NW'(1);
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (known)
                        begin
                            if (!evict_reg[fidx])
                                res_reg.status <= ST_PINNED;
                            else
                            begin
                                tracked_reg[fidx] <= 1'b0;
                                evict_reg[fidx]   <= 1'b0;
                                live_reg          <= live_reg - NW'(1);
                                evcnt_reg         <= evcnt_reg - NW'(1);
                            end
                        end
                    end
                    default: ;
                endcase
            end

            if (scanning)
            begin
                // stage 0: issue meta read
                s1_v_reg   <= scan_issue;
                s1_idx_reg <= scan_cnt_reg[FW-1:0];
                if (scan_issue)
                    scan_cnt_reg <= scan_cnt_reg + (FW+1)'(1);
                // stage 1: meta data back, issue history read
                s2_v_reg     <= s1_v_reg && tracked_reg[s1_idx_reg] && evict_reg[s1_idx_reg];
                s2_idx_reg   <= s1_idx_reg;
                s2_young_reg <= m_cnt < k_eff;
                s2_first_reg <= m_first;
                // stage 2: compare
                if (s2_v_reg)
                begin
                    if (s2_young_reg)
                    begin
                        if (!have_y_reg || s2_first_reg < y_t_reg)
                        begin
                            have_y_reg <= 1'b1;
                            y_idx_reg  <= s2_idx_reg;
                            y_t_reg    <= s2_first_reg;
                        end
                    end
                    else if (!have_o_reg || hist_rdata < o_t_reg)
                    begin
                        have_o_reg <= 1'b1;
                        o_idx_reg  <= s2_idx_reg;
                        o_t_reg    <= hist_rdata;
                    end
                end
            end

            if (state_reg == S_DONE)
            begin
                res_reg.status        <= ST_OK;
                res_reg.evicted_valid <= victim_v;
                res_reg.evicted_frame <= victim_v ? 6'(victim) : '0;
                if (victim_v)
                begin
                    // victim is evictable, so both counts drop
                    tracked_reg[victim] <= 1'b0;
                    evict_reg[victim]   <= 1'b0;
                    live_reg            <= live_reg - NW'(1);
                    evcnt_reg           <= evcnt_reg - NW'(1);
                end
            end

            if (state_reg == S_OUT)
            begin
                res_valid_reg           <= 1'b1;
                res_reg.evictable_count <= 7'(evcnt_reg);
                res_reg.tracked_count   <= 7'(live_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            cmd_reg <= in_word;
    end
endmodule

// File: rtl/core/lruk_checker.sv
// Port-level checker for the LRU-K replacer, bound to the top level
`include "assert_macros.svh"
module lruk_checker
    import lruk_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_word
);
    `CHK_IMPLY(a_one_item, clk, rst_n, in_ready, !out_valid, "accepting with result pending")
    `CHK_NEXT(a_no_accept_after, clk, rst_n, in_valid && in_ready, !in_ready, "two words in flight")
    `CHK_IMPLY(a_ev_frame_zero, clk, rst_n, out_valid && !out_word.evicted_valid, out_word.evicted_frame == 6'd0, "frame without victim")
    `CHK_IMPLY(a_counts, clk, rst_n, out_valid, out_word.evictable_count <= out_word.tracked_count, "evictable above tracked")
    `CHK_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word), "result dropped")
endmodule

bind lru_k_replacement_policy lruk_checker u_lruk_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
);
